FILE: hw/rtl/json_string_escaper_unit_macros.svh
// assertion macros for the json string escaper
`ifndef JSON_STRING_ESCAPER_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during rst
`define JSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define JSE_ASSERT_NOW(lbl, ante, cons, msg)
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/jse_pkg.sv
package jse_pkg;

  typedef logic [7:0] byte_t;

  // input operation codes
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // held utf-8 prefix codes
  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_E2    = 2'd1;
  localparam logic [1:0] HOLD_E2_80 = 2'd2;

  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned ESC_MAX     = 6;

  // characters
  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5c;
  localparam byte_t CH_U      = 8'h75;
  localparam byte_t CH_B      = 8'h62;
  localparam byte_t CH_F      = 8'h66;
  localparam byte_t CH_N      = 8'h6e;
  localparam byte_t CH_R      = 8'h72;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_DEL    = 8'h7f;
  localparam byte_t UTF_LEAD  = 8'he2;
  localparam byte_t UTF_MID   = 8'h80;
  localparam byte_t UTF_LSEP  = 8'ha8;
  localparam byte_t UTF_PSEP  = 8'ha9;

  typedef struct packed {
    byte_t [MAX_RESULTS-1:0] bytes;
    logic [CNT_W-1:0]        count;
    logic [1:0]              held;
  } esc_result_t;

  // lowercase hex digit
  function automatic byte_t hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h57 + {4'h0, n};
  endfunction

  // all result bytes and the next hold for one input item
  function automatic esc_result_t escape_item(input logic [1:0] op, input byte_t c,
                                              input logic mode, input logic [1:0] held);
    byte_t [1:0]         fl;
    logic [1:0]          fl_n;
    byte_t [ESC_MAX-1:0] es;
    logic [2:0]          es_n;
    logic [1:0]          hold_in;
    logic [1:0]          held_nx;
    logic                do_flush;
    logic                want_u;
    logic                want_short;
    logic                want_pass;
    logic                want_quote;
    logic                short_hit;
    byte_t               short_chr;
    logic [15:0]         code;
    logic [2:0]          k;
    esc_result_t         r;

    hold_in    = (held == HOLD_E2 || held == HOLD_E2_80) ? held : HOLD_NONE;
    held_nx    = hold_in;
    do_flush   = 1'b0;
    want_u     = 1'b0;
    want_short = 1'b0;
    want_pass  = 1'b0;
    want_quote = 1'b0;
    code       = {8'h00, c};

    // short escape decode
    short_hit = 1'b1;
    case (c)
      CH_QUOTE:  short_chr = CH_QUOTE;
      CH_BSLASH: short_chr = CH_BSLASH;
      8'h08:     short_chr = CH_B;
      8'h0c:     short_chr = CH_F;
      8'h0a:     short_chr = CH_N;
      8'h0d:     short_chr = CH_R;
      8'h09:     short_chr = CH_T;
      default: begin
        short_hit = 1'b0;
        short_chr = CH_NUL;
      end
    endcase

    // classify the item
    case (op)
      OP_OPEN, OP_CLOSE: begin
        do_flush   = 1'b1;
        want_quote = 1'b1;
        held_nx    = HOLD_NONE;
      end
      OP_DATA: begin
        if (mode) begin
          do_flush = 1'b1;
          held_nx  = HOLD_NONE;
          if (short_hit) begin
            want_short = 1'b1;
          end else if (c < CH_SPACE || c >= CH_DEL) begin
            want_u = 1'b1;
          end else begin
            want_pass = 1'b1;
          end
        end else if (hold_in == HOLD_E2 && c == UTF_MID) begin
          held_nx = HOLD_E2_80;
        end else if (hold_in == HOLD_E2_80 && (c == UTF_LSEP || c == UTF_PSEP)) begin
          held_nx = HOLD_NONE;
          want_u  = 1'b1;
          code    = {8'h20, (c == UTF_LSEP) ? 8'h28 : 8'h29};
        end else begin
          do_flush = 1'b1;
          held_nx  = HOLD_NONE;
          if (short_hit) begin
            want_short = 1'b1;
          end else if (c < CH_SPACE) begin
            want_u = 1'b1;
          end else if (c == UTF_LEAD) begin
            held_nx = HOLD_E2;
          end else begin
            want_pass = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // held bytes go out first
    fl[0] = UTF_LEAD;
    fl[1] = UTF_MID;
    fl_n  = do_flush ? hold_in : 2'd0;

    // escape body
    es = '0;
    es_n = 3'd0;
    if (want_quote) begin
      es[0] = CH_QUOTE;
      es_n  = 3'd1;
    end else if (want_pass) begin
      es[0] = c;
      es_n  = 3'd1;
    end else if (want_short) begin
      es[0] = CH_BSLASH;
      es[1] = short_chr;
      es_n  = 3'd2;
    end else if (want_u) begin
      es[0] = CH_BSLASH;
      es[1] = CH_U;
      es[2] = hex_char(code[15:12]);
      es[3] = hex_char(code[11:8]);
      es[4] = hex_char(code[7:4]);
      es[5] = hex_char(code[3:0]);
      es_n  = 3'd6;
    end

    // line up flush bytes then escape bytes
    for (int i = 0; i < MAX_RESULTS; i++) begin
      k = 3'(i) - {1'b0, fl_n};
      if (3'(i) < {1'b0, fl_n}) begin
        r.bytes[i] = fl[i[0]];
      end else if (k < 3'(ESC_MAX)) begin
        r.bytes[i] = es[k];
      end else begin
        r.bytes[i] = CH_NUL;
      end
    end
    r.count = CNT_W'(fl_n) + CNT_W'(es_n);
    r.held  = held_nx;
    return r;
  endfunction

endpackage

FILE: hw/rtl/jse_if.sv
// input channel: one operation per beat
interface jse_in_if;
  import jse_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  byte_t      data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// output channel: one character per beat
interface jse_out_if;
  import jse_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: hw/rtl/json_string_escaper_unit.sv
// JSON string escaper. Each input beat is open or close (each flushes held
// bytes and emits a quote) or data (emits the escaped byte). An accepted
// item is expanded in the same cycle into up to eight characters, which are
// loaded into a result buffer and sent one per output beat, the last one
// marked with last_of_run. The next item is taken in the cycle the final
// character leaves, so items of at most one character flow at one per cycle
// while the output is ready. Items that yield nothing (a held E2 or E2 80
// prefix) never stall. The user must write the escape_mode register only
// while the block is idle; the block itself does not enforce this.
`include "json_string_escaper_unit_macros.svh"

module json_string_escaper_unit
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  jse_in_if.sink     in_ch,
  jse_out_if.source  out_ch,
  input  logic       escape_mode_we,
  input  logic       escape_mode_wdata
);

  logic                    escape_mode;
  logic [1:0]              held;
  logic [CNT_W-1:0]        rem;
  byte_t [MAX_RESULTS-1:0] res_bytes;
  esc_result_t             res;
  logic                    accept;
  logic                    fire;
  logic                    take_mid;
  logic                    take_close;

  // handshakes
  assign accept       = in_ch.valid && in_ch.ready;
  assign fire         = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (rem == '0) || (rem == CNT_W'(1) && out_ch.ready);

  // expand the incoming item
  assign res = escape_item(in_ch.op, in_ch.data_byte, escape_mode, held);

  // output side
  assign out_ch.valid       = (rem != '0);
  assign out_ch.out_byte    = res_bytes[0];
  assign out_ch.last_of_run = (rem == CNT_W'(1));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= 1'b0;
      held        <= HOLD_NONE;
      rem         <= '0;
    end else begin
      if (escape_mode_we) begin
        escape_mode <= escape_mode_wdata;
      end
      if (accept) begin
        held <= res.held;
        rem  <= res.count;
      end else if (fire) begin
        rem <= rem - CNT_W'(1);
      end
    end
  end

  // result buffer, shifts one character per beat
  always_ff @(posedge clk) begin
    if (accept) begin
      res_bytes <= res.bytes;
    end else if (fire) begin
      res_bytes <= {CH_NUL, res_bytes[MAX_RESULTS-1:1]};
    end
  end

  // assertion terms
  assign take_mid   = accept && in_ch.op == OP_DATA && !escape_mode
                      && held == HOLD_E2 && in_ch.data_byte == UTF_MID;
  assign take_close = accept && in_ch.op == OP_CLOSE && held == HOLD_NONE;

  // a held E2 80 prefix means every earlier character has left
  `JSE_ASSERT_NOW(a_hold_idle, held == HOLD_E2_80, !out_ch.valid, "output busy while holding")

  // E2 then 80 in string mode keeps holding and sends nothing
  `JSE_ASSERT_NEXT(a_hold_grow, take_mid, held == HOLD_E2_80 && !out_ch.valid, "prefix lost")

  // close with nothing held is a lone final quote
  `JSE_ASSERT_NEXT(a_close_quote, take_close, out_ch.valid && out_ch.out_byte == CH_QUOTE && out_ch.last_of_run, "bad quote")

endmodule

FILE: bench/json_string_escaper_unit_tb.sv
module json_string_escaper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jse_pkg::*;

  // op code with no meaning, the block drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // control characters that have a short escape
  localparam byte_t CH_BS_CTRL  = 8'h08;
  localparam byte_t CH_TAB_CTRL = 8'h09;
  localparam byte_t CH_LF_CTRL  = 8'h0a;
  localparam byte_t CH_FF_CTRL  = 8'h0c;
  localparam byte_t CH_CR_CTRL  = 8'h0d;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_CYCLES = 300;

  typedef struct packed {
    logic [1:0] op;
    byte_t      data;
  } op_beat_t;

  typedef struct packed {
    byte_t ch;
    logic  last;
  } char_beat_t;

  logic clk;
  logic rst;
  logic escape_mode_we;
  logic escape_mode_wdata;

  jse_in_if  in_ch ();
  jse_out_if out_ch ();

  json_string_escaper_unit dut (
    .clk               (clk),
    .rst               (rst),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .escape_mode_we    (escape_mode_we),
    .escape_mode_wdata (escape_mode_wdata)
  );

  // pending input beats, escaped characters still owed
  op_beat_t   pending_ops[$];
  char_beat_t owed_chars[$];
  byte_t      run_chars[$];

  // mirror of the block state
  logic       mode_q;
  logic [1:0] hold_q;

  int send_idle_pct;
  int recv_idle_pct;
  int ops_queued;
  int ops_taken;
  int beats_checked;
  int errors;
  int stall_kick;
  int stall_seen;
  int stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("json_string_escaper_unit_tb: done, errors");
    $finish;
  end

  // append one character to the current run
  function automatic void put_char(input byte_t b);
    run_chars = {run_chars, b};
  endfunction

  // held utf-8 prefix goes out literally
  function automatic void emit_held();
    if (hold_q == HOLD_E2 || hold_q == HOLD_E2_80) begin
      put_char(UTF_LEAD);
    end
    if (hold_q == HOLD_E2_80) begin
      put_char(UTF_MID);
    end
    hold_q = HOLD_NONE;
  endfunction

  // \uXXXX with lowercase hex
  function automatic void emit_u(input logic [15:0] code);
    logic [3:0] nib;
    put_char(CH_BSLASH);
    put_char(CH_U);
    for (int i = 3; i >= 0; i--) begin
      nib = code[i*4 +: 4];
      put_char((nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib}));
    end
  endfunction

  // two-character escape, 0 if the byte has none
  function automatic bit emit_short(input byte_t c);
    byte_t esc;
    case (c)
      CH_QUOTE:    esc = CH_QUOTE;
      CH_BSLASH:   esc = CH_BSLASH;
      CH_BS_CTRL:  esc = CH_B;
      CH_FF_CTRL:  esc = CH_F;
      CH_LF_CTRL:  esc = CH_N;
      CH_CR_CTRL:  esc = CH_R;
      CH_TAB_CTRL: esc = CH_T;
      default:     return 1'b0;
    endcase
    put_char(CH_BSLASH);
    put_char(esc);
    return 1'b1;
  endfunction

  // characters one accepted op produces, queued as owed beats
  function automatic void escape_op(input logic [1:0] op, input byte_t c);
    char_beat_t cb;
    run_chars.delete();
    case (op)
      OP_OPEN, OP_CLOSE: begin
        emit_held();
        put_char(CH_QUOTE);
      end
      OP_DATA: begin
        if (mode_q) begin
          // bytes rules: flush, then escape quote, backslash and anything outside printable ascii
          emit_held();
          if (!emit_short(c)) begin
            if (c < CH_SPACE || c >= CH_DEL) begin
              emit_u({8'h00, c});
            end else begin
              put_char(c);
            end
          end
        end else if (hold_q == HOLD_E2 && c == UTF_MID) begin
          hold_q = HOLD_E2_80;
        end else if (hold_q == HOLD_E2_80 && (c == UTF_LSEP || c == UTF_PSEP)) begin
          hold_q = HOLD_NONE;
          emit_u((c == UTF_LSEP) ? 16'h2028 : 16'h2029);
        end else begin
          // broken prefix goes out, byte starts fresh
          emit_held();
          if (!emit_short(c)) begin
            if (c < CH_SPACE) begin
              emit_u({8'h00, c});
            end else if (c == UTF_LEAD) begin
              hold_q = HOLD_E2;
            end else begin
              put_char(c);
            end
          end
        end
      end
      default: begin
      end
    endcase
    foreach (run_chars[i]) begin
      cb.ch   = run_chars[i];
      cb.last = (i == run_chars.size() - 1);
      owed_chars = {owed_chars, cb};
    end
  endfunction

  // input driver
  always @(posedge clk) begin : drive_blk
    op_beat_t nxt;
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.op        <= OP_OPEN;
      in_ch.data_byte <= 8'h00;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_ops.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= nxt.op;
        in_ch.data_byte <= nxt.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_seen   <= 0;
      stall_left   <= 0;
    end else if (stall_seen != stall_kick) begin
      stall_seen   <= stall_kick;
      stall_left   <= STALL_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on input beats, track config, check output beats
  always @(posedge clk) begin : watch_blk
    char_beat_t want;
    if (rst) begin
      mode_q = 1'b0;
      hold_q = HOLD_NONE;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ops_taken++;
        escape_op(in_ch.op, in_ch.data_byte);
      end
      if (escape_mode_we) begin
        mode_q = escape_mode_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (owed_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got out_byte=%h last_of_run=%b",
                   $time, out_ch.out_byte, out_ch.last_of_run);
        end else begin
          want = owed_chars.pop_front();
          if (out_ch.out_byte !== want.ch) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %h, got %h",
                     $time, want.ch, out_ch.out_byte);
          end
          if (out_ch.last_of_run !== want.last) begin
            errors++;
            $display("%0t: last_of_run mismatch, expected %b, got %b",
                     $time, want.last, out_ch.last_of_run);
          end
        end
      end
    end
  end

  task automatic add_op(input logic [1:0] op, input byte_t data);
    op_beat_t b;
    b.op   = op;
    b.data = data;
    pending_ops = {pending_ops, b};
    if (op != OP_UNUSED) begin
      ops_queued++;
    end
  endtask

  // wait until every queued op is taken and every char has come out
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_ops.size() != 0 || in_ch.valid || owed_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(posedge clk);
    escape_mode_we    <= 1'b1;
    escape_mode_wdata <= v;
    @(posedge clk);
    escape_mode_we    <= 1'b0;
  endtask

  // one chunk of string content, sometimes a multi-byte sequence
  task automatic add_content();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) begin
      add_op(OP_DATA, byte_t'($urandom_range(255)));
    end else if (sel < 50) begin
      add_op(OP_DATA, byte_t'($urandom_range(8'h7e, 8'h20)));
    end else if (sel < 68) begin
      case ($urandom_range(12))
        0:  add_op(OP_DATA, CH_QUOTE);
        1:  add_op(OP_DATA, CH_BSLASH);
        2:  add_op(OP_DATA, CH_BS_CTRL);
        3:  add_op(OP_DATA, CH_FF_CTRL);
        4:  add_op(OP_DATA, CH_LF_CTRL);
        5:  add_op(OP_DATA, CH_CR_CTRL);
        6:  add_op(OP_DATA, CH_TAB_CTRL);
        7:  add_op(OP_DATA, CH_DEL);
        8:  add_op(OP_DATA, byte_t'($urandom_range(8'h1f, 8'h00)));
        9:  add_op(OP_DATA, byte_t'($urandom_range(8'hff, 8'h80)));
        10: add_op(OP_DATA, UTF_LEAD);
        11: add_op(OP_DATA, CH_SPACE);
        default: add_op(OP_DATA, UTF_MID);
      endcase
    end else if (sel < 84) begin
      // line or paragraph separator
      add_op(OP_DATA, UTF_LEAD);
      add_op(OP_DATA, UTF_MID);
      add_op(OP_DATA, $urandom_range(1) ? UTF_LSEP : UTF_PSEP);
    end else if (sel < 95) begin
      // prefix followed by a random byte, which mostly breaks it off
      add_op(OP_DATA, UTF_LEAD);
      if ($urandom_range(1)) begin
        add_op(OP_DATA, UTF_MID);
      end
      add_op(OP_DATA, byte_t'($urandom_range(255)));
    end else begin
      // prefix left dangling for the next op
      add_op(OP_DATA, UTF_LEAD);
      if ($urandom_range(1)) begin
        add_op(OP_DATA, UTF_MID);
      end
    end
  endtask

  // mostly whole strings, some stray ops and unused codes
  task automatic add_random_traffic(input int n);
    int stop_at;
    int len;
    int sel;
    stop_at = ops_queued + n;
    while (ops_queued < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 82) begin
        add_op(OP_OPEN, byte_t'($urandom_range(255)));
        len = $urandom_range(6);
        for (int i = 0; i < len; i++) begin
          add_content();
        end
        add_op(OP_CLOSE, byte_t'($urandom_range(255)));
      end else if (sel < 90) begin
        add_op(OP_UNUSED, byte_t'($urandom_range(255)));
      end else if (sel < 95) begin
        add_content();
      end else begin
        add_op($urandom_range(1) ? OP_OPEN : OP_CLOSE, byte_t'($urandom_range(255)));
      end
    end
  endtask

  // main sequence
  initial begin
    rst               = 1'b1;
    escape_mode_we    = 1'b0;
    escape_mode_wdata = 1'b0;
    send_idle_pct     = 22;
    recv_idle_pct     = 53;
    ops_queued        = 0;
    stall_kick        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);

    // string rules: extremes, short escapes, separators, broken prefixes
    add_op(OP_OPEN, 8'hff);
    add_op(OP_DATA, 8'h00);
    add_op(OP_DATA, 8'h1f);
    add_op(OP_DATA, CH_SPACE);
    add_op(OP_DATA, CH_QUOTE);
    add_op(OP_DATA, CH_BSLASH);
    add_op(OP_DATA, CH_BS_CTRL);
    add_op(OP_DATA, CH_FF_CTRL);
    add_op(OP_DATA, CH_LF_CTRL);
    add_op(OP_DATA, CH_CR_CTRL);
    add_op(OP_DATA, CH_TAB_CTRL);
    add_op(OP_DATA, CH_DEL);
    add_op(OP_DATA, 8'hff);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_DATA, UTF_MID);
    add_op(OP_DATA, UTF_LSEP);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_DATA, UTF_MID);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_DATA, UTF_MID);
    add_op(OP_DATA, 8'h01);
    add_op(OP_UNUSED, 8'h5a);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_CLOSE, 8'h00);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_DATA, UTF_MID);
    add_op(OP_OPEN, 8'h00);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_DATA, UTF_MID);
    wait_idle();

    // bytes rules, starting with a prefix still held from string rules
    write_mode(1'b1);
    add_op(OP_DATA, CH_DEL);
    add_op(OP_DATA, UTF_LEAD);
    add_op(OP_DATA, CH_TAB_CTRL);
    add_op(OP_DATA, 8'h7e);
    add_op(OP_CLOSE, 8'h00);
    wait_idle();

    // random, sender idles less than receiver
    write_mode(1'b0);
    add_random_traffic(100);
    wait_idle();

    // random, receiver idles less than sender
    send_idle_pct = 53;
    recv_idle_pct = 22;
    write_mode(1'b1);
    add_random_traffic(100);
    wait_idle();

    // no idling, long output hold-off at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(1'b0);
    stall_kick = stall_kick + 1;
    add_random_traffic(65);
    wait_idle();
    write_mode(1'b1);
    add_random_traffic(55);
    wait_idle();

    if (owed_chars.size() != 0) begin
      $display("%0t: %0d characters never came out", $time, owed_chars.size());
    end
    $display("ops taken: %0d, output beats checked: %0d", ops_taken, beats_checked);
    $display("both escape modes, three idle profiles, one long output hold-off");
    if (errors == 0 && owed_chars.size() == 0) begin
      $display("json_string_escaper_unit_tb: done, clean");
    end else begin
      $display("json_string_escaper_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/jse_pkg.sv
hw/rtl/jse_if.sv
hw/rtl/json_string_escaper_unit.sv
bench/json_string_escaper_unit_tb.sv
